// File: src/vap_pkg.sv
// vertex attribute packer package: word types, format codes, per-format lane set-up
// no dependencies
package vap_pkg;

  // format codes
  localparam logic [3:0] FMT_F1   = 4'd0;
  localparam logic [3:0] FMT_F2   = 4'd1;
  localparam logic [3:0] FMT_S2   = 4'd2;
  localparam logic [3:0] FMT_S2N  = 4'd3;
  localparam logic [3:0] FMT_F3   = 4'd4;
  localparam logic [3:0] FMT_F4   = 4'd5;
  localparam logic [3:0] FMT_S4   = 4'd6;
  localparam logic [3:0] FMT_S4N  = 4'd7;
  localparam logic [3:0] FMT_UB4  = 4'd8;
  localparam logic [3:0] FMT_UB4N = 4'd9;
  localparam logic [3:0] FMT_B4   = 4'd10;
  localparam logic [3:0] FMT_B4N  = 4'd11;

  localparam int unsigned NumLanes = 4;

  // float32 biased exponents that bound the conversion paths
  localparam logic [7:0] ExpOne     = 8'd127;  // 1.0
  localparam logic [7:0] ExpIntSat  = 8'd151;  // 2^24, above every integer limit
  localparam logic [7:0] ExpNormLow = 8'd110;  // below 2^-17 scaled value is under 0.25
  localparam logic [7:0] ExpUnit    = 8'd150;  // exponent where the lsb of m weighs 1
  localparam logic [7:0] ExpNan     = 8'd255;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_INT,
    KIND_NORM
  } lane_kind_e;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
  } vap_in_t;

  typedef struct packed {
    logic [31:0] lane0;
    logic [31:0] lane1;
    logic [31:0] lane2;
    logic [31:0] lane3;
    logic [4:0]  bytes_written;
    logic        bad_format;
  } vap_out_t;

  typedef struct packed {
    lane_kind_e  kind;
    logic [2:0]  n_lanes;
    logic [4:0]  bytes;
    logic        bad;
    logic [14:0] scale;
    logic [3:0]  scale_msb;
    logic [15:0] pos_max;
    logic [15:0] neg_max;
    logic        is_unsigned;
    logic        narrow;
  } fmt_cfg_t;

  typedef struct packed {
    logic [4:0] bytes;
    logic       bad;
  } item_info_t;

  function automatic fmt_cfg_t decode_fmt(input logic [3:0] func);
    fmt_cfg_t c;
    c = '{kind: KIND_PASS, n_lanes: 3'd0, bytes: 5'd0, bad: 1'b0, scale: 15'd0,
          scale_msb: 4'd0, pos_max: 16'd0, neg_max: 16'd0, is_unsigned: 1'b0,
          narrow: 1'b0};
    unique case (func)
      FMT_F1: begin c.n_lanes = 3'd1; c.bytes = 5'd4; end
      FMT_F2: begin c.n_lanes = 3'd2; c.bytes = 5'd8; end
      FMT_F3: begin c.n_lanes = 3'd3; c.bytes = 5'd12; end
      FMT_F4: begin c.n_lanes = 3'd4; c.bytes = 5'd16; end
      FMT_S2, FMT_S4: begin
        c.kind = KIND_INT;
        c.n_lanes = (func == FMT_S2) ? 3'd2 : 3'd4;
        c.bytes = (func == FMT_S2) ? 5'd4 : 5'd8;
        c.pos_max = 16'd32767;
        c.neg_max = 16'd32768;
      end
      FMT_S2N, FMT_S4N: begin
        c.kind = KIND_NORM;
        c.n_lanes = (func == FMT_S2N) ? 3'd2 : 3'd4;
        c.bytes = (func == FMT_S2N) ? 5'd4 : 5'd8;
        c.scale = 15'd32767;
        c.scale_msb = 4'd14;
      end
      FMT_UB4: begin
        c.kind = KIND_INT; c.n_lanes = 3'd4; c.bytes = 5'd4;
        c.pos_max = 16'd255; c.is_unsigned = 1'b1; c.narrow = 1'b1;
      end
      FMT_UB4N: begin
        c.kind = KIND_NORM; c.n_lanes = 3'd4; c.bytes = 5'd4;
        c.scale = 15'd255; c.scale_msb = 4'd7; c.is_unsigned = 1'b1; c.narrow = 1'b1;
      end
      FMT_B4: begin
        c.kind = KIND_INT; c.n_lanes = 3'd4; c.bytes = 5'd4;
        c.pos_max = 16'd127; c.neg_max = 16'd128; c.narrow = 1'b1;
      end
      FMT_B4N: begin
        c.kind = KIND_NORM; c.n_lanes = 3'd4; c.bytes = 5'd4;
        c.scale = 15'd127; c.scale_msb = 4'd6; c.narrow = 1'b1;
      end
      default: c.bad = 1'b1;
    endcase
    return c;
  endfunction

endpackage

// File: src/vap_lane.sv
// one conversion lane: float32 component to float, clamped integer or normalised integer
// depends on vap_pkg; first stage registered inside, second stage combinational
module vap_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       comp_i,
  input  vap_pkg::fmt_cfg_t cfg_i,
  input  logic              active_i,
  output logic [31:0]       lane_o
);

  // first stage signals
  logic        sign;
  logic [7:0]  expo;
  logic [23:0] mant;
  logic        is_nan;
  logic [24:0] int_mag;
  logic [15:0] int_lim;
  logic [15:0] int_clip;
  logic [15:0] int_res;
  logic [38:0] prod;
  logic        zero;

  logic [31:0]               bits_q;
  vap_pkg::lane_kind_e       kind_q;
  logic                      zero_q;
  logic                      sign_q;
  logic [7:0]                expo_q;
  logic [38:0]               prod_q;
  logic [15:0]               int_res_q;
  logic [14:0]               scale_q;
  logic [3:0]                msb_q;
  logic                      narrow_q;

  // unpack the float
  always_comb begin
    sign   = comp_i[31];
    expo   = comp_i[30:23];
    mant   = {(expo != 8'd0), comp_i[22:0]};
    is_nan = (expo == vap_pkg::ExpNan) && (comp_i[22:0] != 23'd0);
  end

  // plain integer: truncate magnitude, then clamp to the signed or unsigned limit
  always_comb begin
    if (expo >= vap_pkg::ExpIntSat) begin
      int_mag = '1;
    end else if (expo >= vap_pkg::ExpOne) begin
      int_mag = {1'b0, mant} >> 5'(vap_pkg::ExpUnit - expo);
    end else begin
      int_mag = '0;
    end
    int_lim  = sign ? cfg_i.neg_max : cfg_i.pos_max;
    int_clip = (int_mag > {9'd0, int_lim}) ? int_lim : int_mag[15:0];
    int_res  = sign ? 16'(~int_clip + 16'd1) : int_clip;
  end

  // normalised: exact mantissa times scale, rounded in the next stage
  always_comb begin
    prod = 39'(mant) * 39'(cfg_i.scale);
    zero = !active_i ||
           ((cfg_i.kind != vap_pkg::KIND_PASS) && (is_nan || (sign && cfg_i.is_unsigned)));
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bits_q    <= comp_i;
      kind_q    <= cfg_i.kind;
      zero_q    <= zero;
      sign_q    <= sign;
      expo_q    <= expo;
      prod_q    <= prod;
      int_res_q <= int_res;
      scale_q   <= cfg_i.scale;
      msb_q     <= cfg_i.scale_msb;
      narrow_q  <= cfg_i.narrow;
    end
  end

  // second stage: float32 round to nearest even, then round half away from zero
  logic        hi;
  logic [3:0]  drop;
  logic        lsb_b;
  logic        grd_b;
  logic        stk_b;
  logic        rnd;
  logic [40:0] prod_r;
  logic [5:0]  fsh;
  logic [40:0] sum;
  logic [15:0] nmag;
  logic [15:0] norm_mag;
  logic [15:0] norm_res;
  logic [15:0] res;

  always_comb begin
    hi     = prod_q[6'(msb_q) + 6'd24];
    drop   = hi ? 4'(msb_q + 4'd1) : msb_q;
    lsb_b  = prod_q[drop];
    grd_b  = prod_q[4'(drop - 4'd1)];
    stk_b  = (prod_q & ((39'd1 << 4'(drop - 4'd1)) - 39'd1)) != 39'd0;
    rnd    = grd_b && (stk_b || lsb_b);
    prod_r = (({2'b0, prod_q} >> drop) + 41'(rnd)) << drop;
    fsh    = 6'(vap_pkg::ExpUnit - expo_q);
    sum    = prod_r + (41'd1 << 6'(fsh - 6'd1));
    nmag   = 16'(sum >> fsh);
    if (expo_q >= vap_pkg::ExpOne) begin
      norm_mag = {1'b0, scale_q};
    end else if (expo_q < vap_pkg::ExpNormLow) begin
      norm_mag = '0;
    end else begin
      norm_mag = nmag;
    end
    norm_res = sign_q ? 16'(~norm_mag + 16'd1) : norm_mag;
    res      = (kind_q == vap_pkg::KIND_NORM) ? norm_res : int_res_q;
  end

  // lane word
  always_comb begin
    if (zero_q) begin
      lane_o = '0;
    end else if (kind_q == vap_pkg::KIND_PASS) begin
      lane_o = bits_q;
    end else if (narrow_q) begin
      lane_o = {24'd0, res[7:0]};
    end else begin
      lane_o = {16'd0, res};
    end
  end

endmodule

// File: src/vap_merge.sv
// merge stage: gathers the lane words and item info into one output word
// depends on vap_pkg
module vap_merge (
  input  logic [31:0]         lane_i [vap_pkg::NumLanes],
  input  vap_pkg::item_info_t info_i,
  output vap_pkg::vap_out_t   word_o
);

  // unknown formats already have every lane forced to zero
  always_comb begin
    word_o.lane0         = lane_i[0];
    word_o.lane1         = lane_i[1];
    word_o.lane2         = lane_i[2];
    word_o.lane3         = lane_i[3];
    word_o.bytes_written = info_i.bad ? 5'd0 : info_i.bytes;
    word_o.bad_format    = info_i.bad;
  end

endmodule

// File: src/vertex_attribute_packer_unit.sv
// vertex attribute packer: four-lane float32 to vertex format conversion
// lane multiply stage, lane stage register, rounding stage, then output register
// one word per cycle sustained while out_stall_i is low
// asynchronous active-low reset clears the valid bits; data registers are not reset
// depends on vap_pkg, vap_lane, vap_merge
module vertex_attribute_packer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vap_pkg::vap_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vap_pkg::vap_out_t out_word_o
);

  logic                v1_q;
  logic                v2_q;
  logic                en1;
  logic                en2;
  vap_pkg::fmt_cfg_t   cfg;
  vap_pkg::item_info_t info_q;
  logic [31:0]         comp [vap_pkg::NumLanes];
  logic [31:0]         lane [vap_pkg::NumLanes];
  vap_pkg::vap_out_t   merged;
  vap_pkg::vap_out_t   out_q;

  // stage enables, bubbles collapse
  always_comb begin
    en2        = !v2_q || !out_stall_i;
    en1        = !v1_q || en2;
    in_stall_o = !en1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // format decode
  always_comb begin
    cfg     = vap_pkg::decode_fmt(in_word_i.func);
    comp[0] = in_word_i.comp_x;
    comp[1] = in_word_i.comp_y;
    comp[2] = in_word_i.comp_z;
    comp[3] = in_word_i.comp_w;
  end

  always_ff @(posedge clk_i) begin
    if (en1) info_q <= '{bytes: cfg.bytes, bad: cfg.bad};
  end

  // conversion lanes
  for (genvar g = 0; g < vap_pkg::NumLanes; g++) begin : g_lane
    vap_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en1),
      .comp_i   (comp[g]),
      .cfg_i    (cfg),
      .active_i (3'(g) < cfg.n_lanes),
      .lane_o   (lane[g])
    );
  end

  vap_merge u_merge (
    .lane_i (lane),
    .info_i (info_q),
    .word_o (merged)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (en2) out_q <= merged;
  end

  assign out_valid_o = v2_q;
  assign out_word_o  = out_q;

endmodule

// File: src/vap_checker.sv
// port-level checker for the vertex attribute packer, bound to the top level
// depends on vap_pkg and vertex_attribute_packer_unit
module vap_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input vap_pkg::vap_out_t out_word_o
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // input only stalls when the output side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // an accepted word reaches the output if the output is not stalled while it sits in the lane stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // unknown formats give an empty attribute
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bad_format |->
      out_word_o.bytes_written == 5'd0 && out_word_o.lane0 == 32'd0)
    else $error("bad format word not empty");

endmodule

bind vertex_attribute_packer_unit vap_checker u_vap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
